### sv/tpci_pkg.sv
// ----------------------------------------------------------------------------
// tpci_pkg: shared types and constants of the triangle colour interpolator
// Holds field widths, register indexes, the configuration and geometry
// structures and the colour channel selector.
// ----------------------------------------------------------------------------
package tpci_pkg;

  localparam int unsigned COORD_BITS_DEF = 10;
  localparam int unsigned FRAC_BITS_DEF  = 4;

  // Field widths of the channels and the register port.
  localparam int unsigned XW    = 10;
  localparam int unsigned CHW   = 8;
  localparam int unsigned LANES = 3;
  localparam int unsigned AW    = 5;
  localparam int unsigned IW    = 3;
  localparam int unsigned DATW  = 32;

  // Arithmetic widths: vertex, edge, absolute determinant, numerator.
  localparam int unsigned VW   = 16;
  localparam int unsigned EW   = VW + 1;
  localparam int unsigned DETW = 2 * EW;
  localparam int unsigned PW   = DETW + CHW;
  localparam int unsigned NNW  = PW + 1;
  localparam int unsigned DDW  = DETW + 1;
  localparam int unsigned QB   = CHW;

  localparam logic [IW-1:0] REG_VERTEX_A = 3'd0;
  localparam logic [IW-1:0] REG_VERTEX_B = 3'd1;
  localparam logic [IW-1:0] REG_VERTEX_C = 3'd2;
  localparam logic [IW-1:0] REG_COLOR_A  = 3'd3;
  localparam logic [IW-1:0] REG_COLOR_B  = 3'd4;
  localparam logic [IW-1:0] REG_COLOR_C  = 3'd5;

  typedef struct packed {
    logic [31:0] vertex_a;
    logic [31:0] vertex_b;
    logic [31:0] vertex_c;
    logic [23:0] color_a;
    logic [23:0] color_b;
    logic [23:0] color_c;
  } cfg_t;

  // Barycentric weights scaled by the absolute determinant.
  typedef struct packed {
    logic            cov;
    logic [DETW-1:0] w0;
    logic [DETW-1:0] wp;
    logic [DETW-1:0] wq;
    logic [DETW-1:0] det;
  } geo_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic          cov;
  } side_t;

  // Lane 0 is red, lane 1 green, lane 2 blue.
  function automatic logic [CHW-1:0] chan_of(logic [23:0] c, int unsigned lane);
    return c[CHW*(LANES-1-lane) +: CHW];
  endfunction

endpackage

### sv/tpci_if.sv
// ----------------------------------------------------------------------------
// tpci_if: pixel and result channels
// Valid/ready channels carrying one pixel position or one shaded result.
// ----------------------------------------------------------------------------
interface tpci_pix_if;
  logic                      valid;
  logic                      ready;
  logic [tpci_pkg::XW-1:0]   pixel_x;
  logic [tpci_pkg::XW-1:0]   pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface tpci_res_if;
  logic                      valid;
  logic                      ready;
  logic [tpci_pkg::XW-1:0]   out_x;
  logic [tpci_pkg::XW-1:0]   out_y;
  logic                      covered;
  logic [tpci_pkg::CHW-1:0]  red;
  logic [tpci_pkg::CHW-1:0]  green;
  logic [tpci_pkg::CHW-1:0]  blue;

  modport source (output valid, output out_x, output out_y, output covered,
                  output red, output green, output blue, input ready);
  modport sink   (input valid, input out_x, input out_y, input covered,
                  input red, input green, input blue, output ready);
endinterface

### sv/tpci_cfg.sv
// ----------------------------------------------------------------------------
// tpci_cfg: triangle configuration registers
// APB-style register file holding the three vertices and their colours.
// ----------------------------------------------------------------------------
module tpci_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tpci_pkg::AW-1:0]   paddr,
  input  logic [tpci_pkg::DATW-1:0] pwdata,
  output logic [tpci_pkg::DATW-1:0] prdata,
  output logic                      pready,
  output tpci_pkg::cfg_t            cfg_o
);
  import tpci_pkg::*;

  cfg_t            cfg_q;
  logic [IW-1:0]   idx;
  logic            wr;

  assign idx    = paddr[AW-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_VERTEX_A: cfg_q.vertex_a <= pwdata;
        REG_VERTEX_B: cfg_q.vertex_b <= pwdata;
        REG_VERTEX_C: cfg_q.vertex_c <= pwdata;
        REG_COLOR_A:  cfg_q.color_a  <= pwdata[23:0];
        REG_COLOR_B:  cfg_q.color_b  <= pwdata[23:0];
        REG_COLOR_C:  cfg_q.color_c  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VERTEX_A: prdata = cfg_q.vertex_a;
      REG_VERTEX_B: prdata = cfg_q.vertex_b;
      REG_VERTEX_C: prdata = cfg_q.vertex_c;
      REG_COLOR_A:  prdata = DATW'(cfg_q.color_a);
      REG_COLOR_B:  prdata = DATW'(cfg_q.color_b);
      REG_COLOR_C:  prdata = DATW'(cfg_q.color_c);
      default:      prdata = '0;
    endcase
  end

endmodule

### sv/tpci_setup.sv
// ----------------------------------------------------------------------------
// tpci_setup: edge functions and inside test
// Five stages: offset, products, differences, winding fix, coverage.
// ----------------------------------------------------------------------------
module tpci_setup #(
  parameter int unsigned FRAC_BITS = tpci_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic [4:0]              en_i,
  input  tpci_pkg::cfg_t          cfg_i,
  input  logic [tpci_pkg::XW-1:0] x_i,
  input  logic [tpci_pkg::XW-1:0] y_i,
  output tpci_pkg::geo_t          geo_o
);
  import tpci_pkg::*;

  localparam int unsigned SW  = XW + FRAC_BITS;
  localparam int unsigned DXW = ((SW > VW - 1) ? SW : VW - 1) + 2;
  localparam int unsigned PRW = EW + DXW;
  localparam int unsigned NW  = PRW + 1;
  localparam int unsigned WW  = NW + 1;
  localparam int unsigned QPW = 2 * EW;
  localparam int unsigned DW  = QPW + 1;

  logic signed [VW-1:0]  ax, ay, bx, by, cx, cy;
  logic signed [EW-1:0]  e1x, e1y, e2x, e2y;
  logic [DXW-1:0]        xs, ys;
  logic signed [DXW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [PRW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [QPW-1:0] qa_q, qb_q;
  logic signed [NW-1:0]  np_q, nq_q, np3_q, nq3_q;
  logic signed [DW-1:0]  det_q, det3_q;
  logic signed [WW-1:0]  w0;
  logic                  neg, cov;
  geo_t                  geo_q;

  assign ax = $signed(cfg_i.vertex_a[31:16]);
  assign ay = $signed(cfg_i.vertex_a[15:0]);
  assign bx = $signed(cfg_i.vertex_b[31:16]);
  assign by = $signed(cfg_i.vertex_b[15:0]);
  assign cx = $signed(cfg_i.vertex_c[31:16]);
  assign cy = $signed(cfg_i.vertex_c[15:0]);

  assign e1x = EW'(bx) - EW'(ax);
  assign e1y = EW'(by) - EW'(ay);
  assign e2x = EW'(cx) - EW'(ax);
  assign e2y = EW'(cy) - EW'(ay);

  // Pixel centre in vertex units, relative to the first vertex.
  assign xs   = DXW'(x_i) << FRAC_BITS;
  assign ys   = DXW'(y_i) << FRAC_BITS;
  assign dx_d = $signed(xs) - DXW'(ax);
  assign dy_d = $signed(ys) - DXW'(ay);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (en_i[1]) begin
      pa_q <= PRW'(e2y) * PRW'(dx_q);
      pb_q <= PRW'(e2x) * PRW'(dy_q);
      pc_q <= PRW'(e1x) * PRW'(dy_q);
      pd_q <= PRW'(e1y) * PRW'(dx_q);
      qa_q <= QPW'(e1x) * QPW'(e2y);
      qb_q <= QPW'(e2x) * QPW'(e1y);
    end
    if (en_i[2]) begin
      np_q  <= NW'(pa_q) - NW'(pb_q);
      nq_q  <= NW'(pc_q) - NW'(pd_q);
      det_q <= DW'(qa_q) - DW'(qb_q);
    end
  end

  // A clockwise triangle is flipped so that the determinant is positive.
  assign neg = det_q[DW-1];

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      np3_q  <= neg ? -np_q : np_q;
      nq3_q  <= neg ? -nq_q : nq_q;
      det3_q <= neg ? -det_q : det_q;
    end
  end

  assign w0  = WW'(det3_q) - WW'(np3_q) - WW'(nq3_q);
  assign cov = (det3_q != '0) && !np3_q[NW-1] && !nq3_q[NW-1] && !w0[WW-1];

  // When covered, every weight lies between zero and the determinant.
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      geo_q.cov <= cov;
      geo_q.w0  <= w0[DETW-1:0];
      geo_q.wp  <= np3_q[DETW-1:0];
      geo_q.wq  <= nq3_q[DETW-1:0];
      geo_q.det <= det3_q[DETW-1:0];
    end
  end

  assign geo_o = geo_q;

endmodule

### sv/tpci_blend.sv
// ----------------------------------------------------------------------------
// tpci_blend: weighted colour sums
// Two stages: per-channel weight products, then the rounded numerator.
// ----------------------------------------------------------------------------
module tpci_blend (
  input  logic                     clk_i,
  input  logic [1:0]               en_i,
  input  tpci_pkg::cfg_t           cfg_i,
  input  tpci_pkg::geo_t           geo_i,
  output logic [tpci_pkg::NNW-1:0] n_o [tpci_pkg::LANES],
  output logic [tpci_pkg::DDW-1:0] d_o
);
  import tpci_pkg::*;

  logic [PW-1:0]   p0_q [LANES];
  logic [PW-1:0]   p1_q [LANES];
  logic [PW-1:0]   p2_q [LANES];
  logic [DETW-1:0] det_q;
  logic [NNW-1:0]  sum  [LANES];
  logic [NNW-1:0]  n_q  [LANES];
  logic [DDW-1:0]  d_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int l = 0; l < LANES; l++) begin
        p0_q[l] <= PW'(chan_of(cfg_i.color_a, l)) * PW'(geo_i.w0);
        p1_q[l] <= PW'(chan_of(cfg_i.color_b, l)) * PW'(geo_i.wp);
        p2_q[l] <= PW'(chan_of(cfg_i.color_c, l)) * PW'(geo_i.wq);
      end
      det_q <= geo_i.det;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum[l] = NNW'(p0_q[l]) + NNW'(p1_q[l]) + NNW'(p2_q[l]);
    end
  end

  // Round to nearest: (2 * num + det) / (2 * det).
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int l = 0; l < LANES; l++) begin
        n_q[l] <= (sum[l] << 1) + NNW'(det_q);
      end
      d_q <= {det_q, 1'b0};
    end
  end

  assign n_o = n_q;
  assign d_o = d_q;

endmodule

### sv/tpci_div.sv
// ----------------------------------------------------------------------------
// tpci_div: pipelined restoring divider
// One quotient bit per stage for each colour lane, most significant first.
// ----------------------------------------------------------------------------
module tpci_div (
  input  logic                     clk_i,
  input  logic [tpci_pkg::QB-1:0]  en_i,
  input  logic [tpci_pkg::NNW-1:0] n_i [tpci_pkg::LANES],
  input  logic [tpci_pkg::DDW-1:0] d_i,
  output logic [tpci_pkg::CHW-1:0] q_o [tpci_pkg::LANES]
);
  import tpci_pkg::*;

  logic [NNW-1:0] rem_q [QB-1][LANES];
  logic [DDW-1:0] dv_q  [QB-1];
  logic [CHW-1:0] qt_q  [QB-1][LANES];
  logic [CHW-1:0] qf_q  [LANES];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int unsigned B = QB - 1 - s;

    logic [NNW-1:0] rin  [LANES];
    logic [CHW-1:0] qin  [LANES];
    logic [NNW-1:0] rout [LANES];
    logic [CHW-1:0] qout [LANES];
    logic [DDW-1:0] din;
    logic [NNW-1:0] trial;

    if (s == 0) begin : g_first
      assign din = d_i;
      for (genvar l = 0; l < LANES; l++) begin : g_l
        assign rin[l] = n_i[l];
        assign qin[l] = '0;
      end
    end else begin : g_next
      assign din = dv_q[s-1];
      for (genvar l = 0; l < LANES; l++) begin : g_l
        assign rin[l] = rem_q[s-1][l];
        assign qin[l] = qt_q[s-1][l];
      end
    end

    assign trial = NNW'(din) << B;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (rin[l] >= trial) begin
          rout[l] = rin[l] - trial;
          qout[l] = qin[l] | (CHW'(1) << B);
        end else begin
          rout[l] = rin[l];
          qout[l] = qin[l];
        end
      end
    end

    if (s < QB - 1) begin : g_reg
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          rem_q[s] <= rout;
          qt_q[s]  <= qout;
          dv_q[s]  <= din;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          qf_q <= qout;
        end
      end
    end
  end

  assign q_o = qf_q;

endmodule

### sv/triangle_pixel_color_interpolator.sv
// ----------------------------------------------------------------------------
// triangle_pixel_color_interpolator: per-pixel triangle coverage and shading
// Tests each pixel against one configured triangle and blends the vertex
// colours with exact barycentric weights.
// ----------------------------------------------------------------------------
// Usage. The triangle (three vertices and three colours) is loaded through
// the APB-style port while no pixels are in flight; pready is always high
// and every register reads back. Pixel positions arrive as beats on pix_i
// and each produces exactly one result beat on res_o, in order, carrying the
// position, the covered flag and the rounded red, green and blue values
// (all zero when the pixel is outside or the triangle is degenerate).
// Each beat passes through fifteen register stages: five of edge arithmetic,
// two of colour sums and eight of a restoring divider that yields one
// quotient bit per stage. One beat is accepted every cycle while the
// receiver keeps up. Each stage carries its own valid bit and advances
// when it is empty or its successor advances, so bubbles close up and the
// block keeps taking beats while a result waits; only a full pipeline
// behind a stalled receiver drops ready. Reset clears the configuration
// registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module triangle_pixel_color_interpolator #(
  parameter int unsigned COORD_BITS = tpci_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = tpci_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tpci_pkg::AW-1:0]   paddr,
  input  logic [tpci_pkg::DATW-1:0] pwdata,
  output logic [tpci_pkg::DATW-1:0] prdata,
  output logic                      pready,
  tpci_pix_if.sink                  pix_i,
  tpci_res_if.source                res_o
);
  import tpci_pkg::*;

  // Stage map: 0..4 edge setup, 5..6 colour sums, 7..14 divider.
  localparam int unsigned NS     = 15;
  localparam int unsigned S_BLND = 5;
  localparam int unsigned S_DIV  = 7;
  localparam int unsigned UB     = (COORD_BITS < XW) ? COORD_BITS : XW;
  localparam logic [XW-1:0] CMASK = XW'((32'd1 << UB) - 32'd1);

  cfg_t            cfg;
  geo_t            geo;
  logic [NNW-1:0]  num [LANES];
  logic [DDW-1:0]  den;
  logic [CHW-1:0]  quo [LANES];
  logic [NS-1:0]   vld_q, vld_d, vin, en;
  logic [XW-1:0]   xm, ym;
  side_t           side_q [NS];
  side_t           side_o;

  tpci_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Only the low COORD_BITS of each coordinate take part.
  assign xm = pix_i.pixel_x & CMASK;
  assign ym = pix_i.pixel_y & CMASK;

  // A stage moves on when it holds nothing or its successor moves on.
  always_comb begin
    en[NS-1] = !vld_q[NS-1] || res_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign vin   = {vld_q[NS-2:0], pix_i.valid};
  assign vld_d = (en & vin) | (~en & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign pix_i.ready = en[0];

  // Position and coverage ride alongside the arithmetic stages.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= '{x: xm, y: ym, cov: 1'b0};
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        if (k == S_BLND) begin
          side_q[k] <= '{x: side_q[k-1].x, y: side_q[k-1].y, cov: geo.cov};
        end else begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  tpci_setup #(
    .FRAC_BITS (FRAC_BITS)
  ) u_setup (
    .clk_i (clk_i),
    .en_i  (en[S_BLND-1:0]),
    .cfg_i (cfg),
    .x_i   (xm),
    .y_i   (ym),
    .geo_o (geo)
  );

  tpci_blend u_blend (
    .clk_i (clk_i),
    .en_i  (en[S_DIV-1:S_BLND]),
    .cfg_i (cfg),
    .geo_i (geo),
    .n_o   (num),
    .d_o   (den)
  );

  tpci_div u_div (
    .clk_i (clk_i),
    .en_i  (en[NS-1:S_DIV]),
    .n_i   (num),
    .d_i   (den),
    .q_o   (quo)
  );

  // The divider's last stage is the output register; uncovered pixels
  // report black whatever the divider made of the unused weights.
  assign side_o        = side_q[NS-1];
  assign res_o.valid   = vld_q[NS-1];
  assign res_o.out_x   = side_o.x;
  assign res_o.out_y   = side_o.y;
  assign res_o.covered = side_o.cov;
  assign res_o.red     = side_o.cov ? quo[0] : '0;
  assign res_o.green   = side_o.cov ? quo[1] : '0;
  assign res_o.blue    = side_o.cov ? quo[2] : '0;

endmodule

### sv/tpci_checker.sv
// ----------------------------------------------------------------------------
// tpci_checker: port-level checks of the interpolator
// Watches the pixel and result channels of the top level.
// ----------------------------------------------------------------------------
module tpci_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [tpci_pkg::XW-1:0]  out_x_i,
  input logic [tpci_pkg::XW-1:0]  out_y_i,
  input logic                     covered_i,
  input logic [tpci_pkg::CHW-1:0] red_i,
  input logic [tpci_pkg::CHW-1:0] green_i,
  input logic [tpci_pkg::CHW-1:0] blue_i
);

  // Back-pressure on the input can only come from a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without a stalled result");

  // Pixels outside the triangle are reported black.
  a_uncov_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !covered_i) |-> (red_i == '0 && green_i == '0 && blue_i == '0))
    else $error("uncovered pixel carries colour");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(out_x_i) && $stable(out_y_i) && $stable(covered_i) &&
       $stable(red_i) && $stable(green_i) && $stable(blue_i)))
    else $error("result changed while stalled");

endmodule

bind triangle_pixel_color_interpolator tpci_checker u_tpci_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_x_i     (res_o.out_x),
  .out_y_i     (res_o.out_y),
  .covered_i   (res_o.covered),
  .red_i       (res_o.red),
  .green_i     (res_o.green),
  .blue_i      (res_o.blue)
);
